@@ src/dpk_pkg.sv @@
// shared types and constants for the debounced pedal key reporter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpk_pkg;

  localparam int NumKeys = 3;
  localparam int KeyIdxW = 2;
  localparam int CfgDataW = 8;
  localparam int CfgIdxW = 3;
  localparam int LockoutW = 7;
  localparam int CountW = 8;

  localparam logic [7:0] ReleaseMark = 8'h80;
  localparam logic [LockoutW-1:0] LockoutReset = 7'd5;

  typedef enum logic [CfgIdxW-1:0] {
    RegKey0Modifier = 3'd0,
    RegKey0Scancode = 3'd1,
    RegKey1Modifier = 3'd2,
    RegKey1Scancode = 3'd3,
    RegKey2Modifier = 3'd4,
    RegKey2Scancode = 3'd5,
    RegLockout      = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [NumKeys-1:0][7:0]   modifier;
    logic [NumKeys-1:0][7:0]   scancode;
    logic [LockoutW-1:0]       lockout;
  } cfg_t;

  typedef struct packed {
    logic               changed;
    logic [NumKeys-1:0] pressed;
  } key_status_t;

endpackage

`default_nettype wire

@@ src/dpk_cfg_regs.sv @@
// configuration registers: per-key modifier and scancode, lockout length
// depends on dpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpk_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dpk_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [dpk_pkg::CfgDataW-1:0]    cfg_data,
  output dpk_pkg::cfg_t                        cfg
);
  import dpk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modifier <= '0;
      cfg.scancode <= '0;
      cfg.lockout  <= LockoutReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        RegKey0Modifier: cfg.modifier[0] <= cfg_data;
        RegKey0Scancode: cfg.scancode[0] <= cfg_data;
        RegKey1Modifier: cfg.modifier[1] <= cfg_data;
        RegKey1Scancode: cfg.scancode[1] <= cfg_data;
        RegKey2Modifier: cfg.modifier[2] <= cfg_data;
        RegKey2Scancode: cfg.scancode[2] <= cfg_data;
        RegLockout:      cfg.lockout     <= cfg_data[LockoutW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/dpk_debounce.sv @@
// debounce state: pressed flags, shared lockout, hundredths counter
// depends on dpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpk_debounce (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [dpk_pkg::NumKeys-1:0]   pins,
  input  wire logic                          tick,
  input  wire logic [dpk_pkg::LockoutW-1:0]  lockout,
  output dpk_pkg::key_status_t               status
);
  import dpk_pkg::*;

  logic [NumKeys-1:0] pressed;
  logic [NumKeys-1:0] pressed_next;
  logic               lockout_done;
  logic               lockout_done_next;
  logic [CountW-1:0]  deadline;
  logic [CountW-1:0]  count;

  logic [CountW-1:0]  gap;
  logic               passed;
  logic               first_ends;
  logic [NumKeys-1:0] eligible;
  logic [NumKeys-1:0] differs;
  logic [NumKeys-1:0] change;
  logic               found;
  logic               changed;

  // signed 8-bit distance from deadline, greater than zero ends the lockout
  assign gap        = count - deadline;
  assign passed     = (gap != '0) && !gap[CountW-1];
  assign first_ends = !lockout_done && passed;
  assign differs    = (~pins) ^ pressed;

  always_comb begin
    eligible    = {NumKeys{lockout_done || first_ends}};
    eligible[0] = lockout_done;
    change      = '0;
    found       = 1'b0;
    for (logic [KeyIdxW-1:0] k = '0; k < KeyIdxW'(NumKeys); k++) begin
      if (!found && eligible[k] && differs[k]) begin
        change[k] = 1'b1;
        found     = 1'b1;
      end
    end
  end

  assign changed           = |change;
  assign pressed_next      = pressed ^ change;
  assign lockout_done_next = (lockout_done || first_ends) && !changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed      <= '0;
      lockout_done <= 1'b0;
      deadline     <= '0;
      count        <= '0;
    end else if (step) begin
      pressed      <= pressed_next;
      lockout_done <= lockout_done_next;
      if (changed) begin
        deadline <= count + CountW'(lockout);
      end
      count <= count + CountW'(tick);
    end
  end

  assign status.changed = changed;
  assign status.pressed = pressed_next;

  // at most one key changes per poll
  assert property (@(posedge clk) disable iff (rst) $onehot0(change))
    else $error("more than one key changed in one poll");

  // a change always restarts the lockout
  assert property (@(posedge clk) disable iff (rst) step && changed |=> !lockout_done)
    else $error("lockout not restarted after a change");

  // no key state moves while the lockout is running and not yet expired
  assert property (@(posedge clk) disable iff (rst)
    step && !lockout_done && !passed |=> pressed == $past(pressed))
    else $error("key state changed during lockout");

  // counter advances by the tick flag only
  assert property (@(posedge clk) disable iff (rst)
    step |=> count == $past(count) + CountW'($past(tick)))
    else $error("hundredths count advanced wrongly");

endmodule

`default_nettype wire

@@ src/dpk_report.sv @@
// report builder and result register
// depends on dpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpk_report (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  dpk_pkg::key_status_t      status,
  input  dpk_pkg::cfg_t             cfg,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [7:0]                modifier_bits,
  output logic [7:0]                key_code_0,
  output logic [7:0]                key_code_1,
  output logic [7:0]                key_code_2
);
  import dpk_pkg::*;

  logic [NumKeys-1:0][7:0] code;
  logic [7:0]              mods;
  logic                    out_valid_next;

  always_comb begin
    mods = '0;
    for (logic [KeyIdxW-1:0] k = '0; k < KeyIdxW'(NumKeys); k++) begin
      if (status.pressed[k]) begin
        code[k] = cfg.scancode[k];
        mods    = mods | cfg.modifier[k];
      end else if (cfg.scancode[k] == '0) begin
        code[k] = '0;
      end else begin
        code[k] = ReleaseMark | cfg.scancode[k];
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      modifier_bits <= mods;
      key_code_0    <= code[0];
      key_code_1    <= code[1];
      key_code_2    <= code[2];
    end
  end

  // a new report never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst) load |-> (!out_valid || out_ready))
    else $error("report overwritten before taken");

  // a report is only built from a poll that changed a key
  assert property (@(posedge clk) disable iff (rst) load |-> status.changed)
    else $error("report without a key change");

  // a waiting report holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_code_0))
    else $error("waiting report lost");

endmodule

`default_nettype wire

@@ src/debounced_pedal_key_reporter.sv @@
// Debounced three-switch key reporter. Each input item is one poll of three
// active-low switch pins and a hundredth-second tick flag; a poll that changes
// a switch state yields one keyboard report item (modifier OR and three key
// codes). A poll can be accepted every cycle while reports are taken; its report
// goes through the input register, then the result register. A report waiting
// for out_ready holds the next poll in the input register, so the input stalls
// once that register is full. The lockout logic and report formatting sit in
// one combinational level between those registers. Configuration is written via
// cfg_we/cfg_index/cfg_data; it must be written only while the block is idle
// (unenforced). Depends on dpk_pkg, dpk_cfg_regs, dpk_debounce, dpk_report.
`timescale 1ns / 1ps
`default_nettype none

module debounced_pedal_key_reporter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      switch_pins,
  input  wire logic                            hundredth_tick,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           modifier_bits,
  output logic [7:0]                           key_code_0,
  output logic [7:0]                           key_code_1,
  output logic [7:0]                           key_code_2,
  input  wire logic                            cfg_we,
  input  wire logic [dpk_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [dpk_pkg::CfgDataW-1:0]    cfg_data
);
  import dpk_pkg::*;

  cfg_t               cfg;
  key_status_t        status;
  logic               in_full;
  logic [NumKeys-1:0] pins;
  logic               tick;
  logic               step;
  logic               load;

  // poll advances when the result slot can take a report
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;
  assign load     = step && status.changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins <= switch_pins;
      tick <= hundredth_tick;
    end
  end

  dpk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpk_debounce u_debounce (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pins    (pins),
    .tick    (tick),
    .lockout (cfg.lockout),
    .status  (status)
  );

  dpk_report u_report (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .status        (status),
    .cfg           (cfg),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .modifier_bits (modifier_bits),
    .key_code_0    (key_code_0),
    .key_code_1    (key_code_1),
    .key_code_2    (key_code_2)
  );

endmodule

`default_nettype wire
